/* hdl/vcsp_pkg.sv */
// ----------------------------------------------------------------------------
// vcsp_pkg
// Types and constants shared by the voxel chunk stream parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vcsp_pkg;

  // result kinds
  localparam logic [1:0] KIND_VOXEL   = 2'd0;
  localparam logic [1:0] KIND_EXTENTS = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_BAD_HDR = 2'd3;

  // little-endian words as they assemble in the shift register
  localparam logic [31:0] MAGIC_VOX = 32'h2058_4F56;
  localparam logic [31:0] ID_MAIN   = 32'h4E49_414D;
  localparam logic [31:0] ID_SIZE   = 32'h455A_4953;
  localparam logic [31:0] ID_XYZI   = 32'h495A_5958;
  localparam logic [31:0] VERSION_A = 32'd200;
  localparam logic [31:0] VERSION_B = 32'd150;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  coord_x;
    logic [7:0]  coord_y;
    logic [7:0]  coord_z;
    logic [7:0]  color_index;
    logic [31:0] extent_x;
    logic [31:0] extent_y;
    logic [31:0] extent_z;
    logic        run_end;
  } out_item_t;

  // work for the back end from one byte: an optional result, then an optional end
  typedef struct packed {
    logic      has_res;
    out_item_t res;
    logic      has_end;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/vox_chunk_stream_parser.sv */
// ----------------------------------------------------------------------------
// vox_chunk_stream_parser
// Byte-serial parser for a chunked voxel model stream.
// ----------------------------------------------------------------------------
//  channel   ports                          transaction
//  input     in_push / in_full / in_item    one file byte and its end flag
//  result    out_pop / out_empty / out_item voxel, extents, end or bad header
//
//  one byte is accepted per cycle unless in_full; the parser decides its results
//  in that cycle; results leave at one per cycle when popped, from a registered
//  output stage, so a byte with two results (its own and the end) shows both in
//  turn; a four-entry queue parts parser and output; in_full is high while it
//  is full; rst_n is synchronous; after it the parser waits for the header magic
// ----------------------------------------------------------------------------
`default_nettype none

module vox_chunk_stream_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire vcsp_pkg::in_item_t  in_item,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output vcsp_pkg::out_item_t      out_item
);

  logic             accept;
  logic             q_push, q_pop, q_full, q_empty;
  vcsp_pkg::entry_t q_in, q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  vcsp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  vcsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  vcsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* hdl/vcsp_front.sv */
// ----------------------------------------------------------------------------
// vcsp_front
// Byte parser: header check, chunk framing, SIZE and XYZI decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire vcsp_pkg::in_item_t in_item,
  output logic                   q_push,
  output vcsp_pkg::entry_t       q_entry
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_ID, PH_LEN, PH_CHILD,
    PH_SIZE, PH_COUNT, PH_RECORD, PH_SKIP, PH_IGNORE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  biw_r, biw_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] chunk_id_r, chunk_id_nxt;
  logic [31:0] content_len_r, content_len_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [23:0] record_r, record_nxt;
  logic [31:0] ext_x_r, ext_x_nxt;
  logic [31:0] ext_y_r, ext_y_nxt;
  logic        hdr_fail_r, hdr_fail_nxt;

  logic [7:0]  b;
  logic [31:0] word_sh;
  logic        word_done;
  logic [1:0]  biw_inc;
  logic        has_res;
  vcsp_pkg::out_item_t res;

  assign b         = in_item.data_byte;
  assign word_sh   = {b, word_r[31:8]};
  assign word_done = (biw_r == 2'd3);
  assign biw_inc   = biw_r + 2'd1;

  always_comb begin
    phase_nxt       = phase_r;
    biw_nxt         = biw_r;
    word_nxt        = word_r;
    chunk_id_nxt    = chunk_id_r;
    content_len_nxt = content_len_r;
    remain_nxt      = remain_r;
    record_nxt      = record_r;
    ext_x_nxt       = ext_x_r;
    ext_y_nxt       = ext_y_r;
    hdr_fail_nxt    = hdr_fail_r;
    has_res         = 1'b0;
    res             = '0;

    unique case (phase_r)
      PH_MAGIC: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          hdr_fail_nxt = (word_sh != vcsp_pkg::MAGIC_VOX);
          phase_nxt    = PH_VERSION;
        end
      end
      PH_VERSION: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          if (hdr_fail_r || (word_sh != vcsp_pkg::VERSION_A &&
                             word_sh != vcsp_pkg::VERSION_B)) begin
            has_res   = 1'b1;
            res.kind  = vcsp_pkg::KIND_BAD_HDR;
            phase_nxt = PH_IGNORE;
          end else begin
            phase_nxt = PH_ID;
          end
        end
      end
      PH_ID: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          chunk_id_nxt = word_sh;
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          content_len_nxt = word_sh;
          phase_nxt       = PH_CHILD;
        end
      end
      PH_CHILD: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          priority if (chunk_id_r == vcsp_pkg::ID_MAIN) begin
            phase_nxt = PH_ID;
          end else if (chunk_id_r == vcsp_pkg::ID_SIZE) begin
            remain_nxt = '0;
            phase_nxt  = PH_SIZE;
          end else if (chunk_id_r == vcsp_pkg::ID_XYZI) begin
            phase_nxt = PH_COUNT;
          end else if (content_len_r == '0) begin
            phase_nxt = PH_ID;
          end else begin
            remain_nxt = content_len_r;
            phase_nxt  = PH_SKIP;
          end
        end
      end
      PH_SIZE: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          priority if (remain_r == 32'd0) begin
            ext_x_nxt  = word_sh;
            remain_nxt = 32'd1;
          end else if (remain_r == 32'd1) begin
            ext_y_nxt  = word_sh;
            remain_nxt = 32'd2;
          end else begin
            has_res      = 1'b1;
            res.kind     = vcsp_pkg::KIND_EXTENTS;
            res.extent_x = ext_x_r;
            res.extent_y = ext_y_r;
            res.extent_z = word_sh;
            remain_nxt   = '0;
            phase_nxt    = PH_ID;
          end
        end
      end
      PH_COUNT: begin
        word_nxt = word_sh;
        biw_nxt  = biw_inc;
        if (word_done) begin
          remain_nxt = word_sh;
          record_nxt = '0;
          phase_nxt  = (word_sh == '0) ? PH_ID : PH_RECORD;
        end
      end
      PH_RECORD: begin
        if (word_done) begin
          has_res         = 1'b1;
          res.kind        = vcsp_pkg::KIND_VOXEL;
          res.coord_x     = record_r[7:0];
          res.coord_y     = record_r[15:8];
          res.coord_z     = record_r[23:16];
          res.color_index = b;
          record_nxt      = '0;
          biw_nxt         = 2'd0;
          remain_nxt      = remain_r - 32'd1;
          if (remain_r == 32'd1) begin
            phase_nxt = PH_ID;
          end
        end else begin
          unique case (biw_r)
            2'd0:    record_nxt[7:0]   = b;
            2'd1:    record_nxt[15:8]  = b;
            default: record_nxt[23:16] = b;
          endcase
          biw_nxt = biw_inc;
        end
      end
      PH_SKIP: begin
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          phase_nxt = PH_ID;
          biw_nxt   = 2'd0;
        end
      end
      default: begin
      end
    endcase

    // short header: no result came from the switch in these phases
    if (in_item.stream_end && (phase_nxt == PH_MAGIC || phase_nxt == PH_VERSION)) begin
      has_res  = 1'b1;
      res      = '0;
      res.kind = vcsp_pkg::KIND_BAD_HDR;
    end

    if (in_item.stream_end) begin
      phase_nxt       = PH_MAGIC;
      biw_nxt         = '0;
      word_nxt        = '0;
      chunk_id_nxt    = '0;
      content_len_nxt = '0;
      remain_nxt      = '0;
      record_nxt      = '0;
      ext_x_nxt       = '0;
      ext_y_nxt       = '0;
      hdr_fail_nxt    = 1'b0;
    end
  end

  assign q_push          = accept && (has_res || in_item.stream_end);
  assign q_entry.has_res = has_res;
  assign q_entry.res     = res;
  assign q_entry.has_end = in_item.stream_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_MAGIC;
      biw_r         <= '0;
      word_r        <= '0;
      chunk_id_r    <= '0;
      content_len_r <= '0;
      remain_r      <= '0;
      record_r      <= '0;
      ext_x_r       <= '0;
      ext_y_r       <= '0;
      hdr_fail_r    <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      biw_r         <= biw_nxt;
      word_r        <= word_nxt;
      chunk_id_r    <= chunk_id_nxt;
      content_len_r <= content_len_nxt;
      remain_r      <= remain_nxt;
      record_r      <= record_nxt;
      ext_x_r       <= ext_x_nxt;
      ext_y_r       <= ext_y_nxt;
      hdr_fail_r    <= hdr_fail_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/vcsp_queue.sv */
// ----------------------------------------------------------------------------
// vcsp_queue
// Short register queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire vcsp_pkg::entry_t push_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output vcsp_pkg::entry_t      head
);

  vcsp_pkg::entry_t                slots_r [vcsp_pkg::QDEPTH];
  logic [vcsp_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [vcsp_pkg::QCNT_W-1:0]     count_r;
  logic                            do_push, do_pop;

  assign full    = (count_r == vcsp_pkg::QCNT_W'(vcsp_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + vcsp_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + vcsp_pkg::QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + vcsp_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - vcsp_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/vcsp_back.sv */
// ----------------------------------------------------------------------------
// vcsp_back
// Result back end: expands queued entries into result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire vcsp_pkg::entry_t q_head,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output vcsp_pkg::out_item_t   out_item
);

  vcsp_pkg::out_item_t out_r, out_nxt;
  vcsp_pkg::out_item_t end_item;
  logic                valid_r, valid_nxt;
  logic                pend_end_r, pend_end_nxt;
  logic                load;

  always_comb begin
    end_item         = '0;
    end_item.kind    = vcsp_pkg::KIND_END;
    end_item.run_end = 1'b1;
  end

  // slot is free when nothing is shown or the shown transaction leaves now
  assign load = !valid_r || out_pop;

  always_comb begin
    out_nxt      = out_r;
    valid_nxt    = valid_r;
    pend_end_nxt = pend_end_r;
    q_pop        = 1'b0;
    if (load) begin
      priority if (pend_end_r) begin
        out_nxt      = end_item;
        valid_nxt    = 1'b1;
        pend_end_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        if (q_head.has_res) begin
          out_nxt         = q_head.res;
          out_nxt.run_end = !q_head.has_end;
          pend_end_nxt    = q_head.has_end;
        end else begin
          out_nxt = end_item;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pend_end_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      pend_end_r <= pend_end_nxt;
    end
  end

  assign out_empty = !valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

/* hdl/vcsp_checker.sv */
// ----------------------------------------------------------------------------
// vcsp_checker
// Port-level checks of the voxel chunk stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_full,
  input wire logic                out_pop,
  input wire logic                out_empty,
  input wire vcsp_pkg::out_item_t out_item
);

  // reset leaves no result waiting and room for input
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("results or full seen right after reset");

  // a result that is not taken stays in place
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  // the end result always closes its byte's run
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == vcsp_pkg::KIND_END) |-> out_item.run_end)
    else $error("end result without run_end");

  // an open run is always finished by the end result in the next cycle
  a_run_followed_by_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_item.run_end) |=>
      (!out_empty && out_item.kind == vcsp_pkg::KIND_END))
    else $error("open run not followed by end result");

  // voxel results carry no extents
  a_voxel_no_extents: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == vcsp_pkg::KIND_VOXEL) |->
      (out_item.extent_x == '0 && out_item.extent_y == '0 && out_item.extent_z == '0))
    else $error("voxel result with nonzero extents");

endmodule

bind vox_chunk_stream_parser vcsp_checker u_vcsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_item  (out_item)
);

`default_nettype wire
